@@ sv/dmbs_pkg.sv @@
// Shared types and constants for the depth map bilinear sampler.
// Request, result, command and status structs, controller states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmbs_pkg;

    localparam int MAX_ROWS    = 128;
    localparam int MAX_COLS    = 128;
    localparam int VALUE_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
    localparam int DEPTH       = MAX_ROWS * MAX_COLS;
    localparam int CFG_BITS    = 8;
    localparam int KIND_BITS   = 2;
    localparam int WEIGHT_BITS = 2 * FRAC_BITS + 1;
    localparam int ACC_BITS    = VALUE_BITS + 2 * FRAC_BITS;
    localparam int STEP_BITS   = 2;

    localparam logic [KIND_BITS-1:0] KIND_WR_DEPTH = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_WR_CONF  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_SAMPLE   = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [STEP_BITS-1:0] STEP_LAST  = 2'd3;
    localparam logic [STEP_BITS-1:0] DRAIN_LAST = 2'd1;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [ROW_BITS-1:0]   row_index;
        logic [COL_BITS-1:0]   col_index;
        logic [FRAC_BITS-1:0]  row_fraction;
        logic [FRAC_BITS-1:0]  col_fraction;
        logic [VALUE_BITS-1:0] write_value;
    } dmbs_request_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] depth_sample;
        logic [VALUE_BITS-1:0] confidence_sample;
        logic                  out_of_range;
    } dmbs_result_t;

    typedef struct packed {
        logic                 load;
        logic                 write;
        logic                 clear;
        logic                 issue;
        logic [STEP_BITS-1:0] step;
        logic                 finish;
    } dmbs_cmd_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 out_of_range;
    } dmbs_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ISSUE,
        ST_DRAIN,
        ST_RESULT
    } dmbs_state_t;

endpackage

`default_nettype wire

@@ sv/dmbs_ctrl.sv @@
// Controller state machine of the depth map bilinear sampler.
// Sequences request capture, map writes, neighbor reads and result strobe.
// Depends on dmbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmbs_ctrl
    import dmbs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire dmbs_status_t status,
    output dmbs_cmd_t         cmd,
    output logic              busy
);

    dmbs_state_t          state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                step_next = '0;
                if (status.kind == KIND_WR_DEPTH || status.kind == KIND_WR_CONF)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.kind == KIND_SAMPLE)
                begin
                    cmd.clear  = 1'b1;
                    state_next = status.out_of_range ? ST_RESULT : ST_ISSUE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                step_next = step_reg + STEP_BITS'(1);
                if (step_reg == DRAIN_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/dmbs_datapath.sv @@
// Datapath of the depth map bilinear sampler: configuration registers,
// depth and confidence maps, weight generation and multiply-accumulate.
// Depends on dmbs_pkg; driven by dmbs_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module dmbs_datapath
    import dmbs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dmbs_request_t request,
    input  wire logic          cfg_valid,
    input  wire logic          cfg_index,
    input  wire logic [CFG_BITS-1:0] cfg_data,
    input  wire dmbs_cmd_t     cmd,
    output dmbs_status_t       status,
    output dmbs_result_t       result
);

    logic [CFG_BITS-1:0]    rows_reg, cols_reg;
    dmbs_request_t          req_reg;
    logic                   oor_reg;
    logic [ROW_BITS-1:0]    r1_reg;
    logic [COL_BITS-1:0]    c1_reg;
    logic [WEIGHT_BITS-1:0] weight_reg [4];
    logic [VALUE_BITS-1:0]  depth_mem [DEPTH];
    logic [VALUE_BITS-1:0]  conf_mem [DEPTH];
    logic [VALUE_BITS-1:0]  depth_q_reg, conf_q_reg;
    logic [STEP_BITS-1:0]   wsel_reg;
    logic                   rd_v_reg, mul_v_reg;
    logic [ACC_BITS-1:0]    prod_depth_reg, prod_conf_reg;
    logic [ACC_BITS-1:0]    acc_depth_reg, acc_conf_reg;

    logic [CFG_BITS-1:0]    nr, nc, row_ext, col_ext, row_inc, col_inc;
    logic                   wr_in_range, oor_next;
    logic [ROW_BITS-1:0]    r1_next;
    logic [COL_BITS-1:0]    c1_next;
    logic [FRAC_BITS:0]     fr, fc, ir, ic;
    logic [WEIGHT_BITS-1:0] w_full [4];
    logic [ADDR_BITS-1:0]   wr_addr, rd_addr;
    logic [ACC_BITS-1:0]    mul_depth, mul_conf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_BITS'(MAX_ROWS);
            cols_reg <= CFG_BITS'(MAX_COLS);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data;
                CFG_COLS: cols_reg <= cfg_data;
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    always_comb
    begin
        nr      = (rows_reg > CFG_BITS'(MAX_ROWS)) ? CFG_BITS'(MAX_ROWS) : rows_reg;
        nc      = (cols_reg > CFG_BITS'(MAX_COLS)) ? CFG_BITS'(MAX_COLS) : cols_reg;
        row_ext = CFG_BITS'(req_reg.row_index);
        col_ext = CFG_BITS'(req_reg.col_index);
        row_inc = row_ext + CFG_BITS'(1);
        col_inc = col_ext + CFG_BITS'(1);
        wr_in_range = (row_ext < nr) && (col_ext < nc);
        oor_next = !wr_in_range
                   || (row_inc == nr && req_reg.row_fraction != '0)
                   || (col_inc == nc && req_reg.col_fraction != '0);
        r1_next = (row_inc < nr) ? row_inc[ROW_BITS-1:0] : req_reg.row_index;
        c1_next = (col_inc < nc) ? col_inc[COL_BITS-1:0] : req_reg.col_index;
        fr = {1'b0, req_reg.row_fraction};
        fc = {1'b0, req_reg.col_fraction};
        ir = (FRAC_BITS+1)'(1 << FRAC_BITS) - fr;
        ic = (FRAC_BITS+1)'(1 << FRAC_BITS) - fc;
        w_full[0] = WEIGHT_BITS'(ic) * WEIGHT_BITS'(ir);
        w_full[1] = WEIGHT_BITS'(fc) * WEIGHT_BITS'(ir);
        w_full[2] = WEIGHT_BITS'(ic) * WEIGHT_BITS'(fr);
        w_full[3] = WEIGHT_BITS'(fc) * WEIGHT_BITS'(fr);
        wr_addr = {req_reg.row_index, req_reg.col_index};
        unique case (cmd.step)
            2'd0:    rd_addr = {req_reg.row_index, req_reg.col_index};
            2'd1:    rd_addr = {req_reg.row_index, c1_reg};
            2'd2:    rd_addr = {r1_reg, req_reg.col_index};
            default: rd_addr = {r1_reg, c1_reg};
        endcase
        mul_depth = ACC_BITS'(depth_q_reg) * ACC_BITS'(weight_reg[wsel_reg]);
        mul_conf  = ACC_BITS'(conf_q_reg) * ACC_BITS'(weight_reg[wsel_reg]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.clear)
        begin
            oor_reg <= oor_next;
            r1_reg  <= r1_next;
            c1_reg  <= c1_next;
            for (int i = 0; i < 4; i++)
            begin
                weight_reg[i] <= w_full[i];
            end
        end
        if (cmd.issue)
        begin
            wsel_reg <= cmd.step;
        end
        prod_depth_reg <= mul_depth;
        prod_conf_reg  <= mul_conf;
        if (cmd.clear)
        begin
            acc_depth_reg <= '0;
            acc_conf_reg  <= '0;
        end
        else if (mul_v_reg)
        begin
            acc_depth_reg <= acc_depth_reg + prod_depth_reg;
            acc_conf_reg  <= acc_conf_reg + prod_conf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_in_range && req_reg.kind == KIND_WR_DEPTH)
        begin
            depth_mem[wr_addr] <= req_reg.write_value;
        end
        if (cmd.issue)
        begin
            depth_q_reg <= depth_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_in_range && req_reg.kind == KIND_WR_CONF)
        begin
            conf_mem[wr_addr] <= req_reg.write_value;
        end
        if (cmd.issue)
        begin
            conf_q_reg <= conf_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= cmd.issue;
            mul_v_reg <= rd_v_reg;
        end
    end

    always_comb
    begin
        status.kind         = req_reg.kind;
        status.out_of_range = oor_next;
        result.out_of_range = oor_reg;
        result.depth_sample = oor_reg ? '0 : acc_depth_reg[ACC_BITS-1 -: VALUE_BITS];
        result.confidence_sample = oor_reg ? '0 : acc_conf_reg[ACC_BITS-1 -: VALUE_BITS];
    end

`ifndef NO_ASSERTIONS
    a_read_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |=> mul_v_reg)
        else $error("read data not followed by product");
    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !oor_reg)
        else $error("neighbor read issued for out-of-range sample");
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rd_v_reg && !mul_v_reg))
        else $error("result strobed with accumulation pending");
`endif

endmodule

`default_nettype wire

@@ sv/depth_map_bilinear_sampler_core.sv @@
// Write and unused requests go from the check state back to idle. Samples pass
// check, neighbor issue, drain and result; out of range, check goes to result.
// Throughput: one request at a time; four reads per map, then multiply-accumulate.
// Results strobe for one cycle and cannot be stalled.
// Reset: asynchronous, active low; returns to idle, rows and columns in use 128.
// Map contents are not cleared. Depends on dmbs_pkg, dmbs_ctrl, dmbs_datapath.
`timescale 1ns / 1ps
`default_nettype none

module depth_map_bilinear_sampler_core
    import dmbs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire dmbs_request_t       request,
    output logic                     result_valid,
    output dmbs_result_t             result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [CFG_BITS-1:0] cfg_data
);

    dmbs_cmd_t    cmd;
    dmbs_status_t status;

    assign cfg_ready    = 1'b1;
    assign result_valid = cmd.finish;

    dmbs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    dmbs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

`default_nettype wire
